// File: rtl/core/srr_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// srr_pkg
// Shared types and constants of the selective-repeat receiver.
// ---------------------------------------------------------------------------
package srr_pkg;

	localparam int MAX_WINDOW = 8;
	localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
	localparam int CFG_W      = 4;
	localparam int SEQ_W      = 32;
	localparam int LEN_W      = 11;
	localparam int TAG_W      = 16;
	localparam int FLEN_W     = 32;
	localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(4);

	typedef enum logic [1:0] {
		FUNC_DATA   = 2'd0,
		FUNC_HEADER = 2'd1,
		FUNC_TAIL   = 2'd2,
		FUNC_FIN    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KIND_ACK     = 2'd0,
		KIND_START   = 2'd1,
		KIND_DELIVER = 2'd2,
		KIND_CLOSE   = 2'd3
	} kind_t;

	// one held packet
	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [LEN_W-1:0] len;
		logic             is_tail;
	} slot_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		slot_t            wdata;
		logic [IDX_W-1:0] raddr;
	} slot_req_t;

	typedef struct packed {
		kind_t             kind;
		logic [SEQ_W-1:0]  ack_seq;
		logic [TAG_W-1:0]  tag;
		logic [LEN_W-1:0]  len;
		logic [SEQ_W-1:0]  offset;
		logic [FLEN_W-1:0] file_len;
		logic              file_end;
		logic              last;
	} res_t;

endpackage
`default_nettype wire

// File: rtl/core/selective_repeat_receiver_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// selective_repeat_receiver_unit
// Selective-repeat ARQ receiver: window store, in-order delivery and ACKs.
// ---------------------------------------------------------------------------
// One packet descriptor is taken at a time; in_ready stays low until every
// result it causes has entered the output register. A packet is first
// registered and then classified, and its results follow one by one; each
// delivered slot takes a slot RAM read and then an emit, and a final RAM
// probe ends the drain. Every result waits while out_ready is low and the
// output register is full. The drain is bounded by the single read port of
// the slot RAM. The window register may be written only while no packet is
// in flight.
module selective_repeat_receiver_unit
	import srr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CFG_W-1:0]  cfg_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        func,
	input  wire logic [SEQ_W-1:0]  seq,
	input  wire logic              corrupt,
	input  wire logic [LEN_W-1:0]  payload_len,
	input  wire logic [TAG_W-1:0]  payload_tag,
	input  wire logic [FLEN_W-1:0] file_len,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [1:0]             kind,
	output logic [SEQ_W-1:0]       ack_seq,
	output logic [TAG_W-1:0]       out_tag,
	output logic [LEN_W-1:0]       out_len,
	output logic [SEQ_W-1:0]       write_offset,
	output logic [FLEN_W-1:0]      out_file_len,
	output logic                   file_end,
	output logic                   last
);

	slot_req_t slot_req;
	slot_t     slot_rdata;
	logic      res_valid;
	logic      res_ready;
	res_t      res;

	srr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.seq         (seq),
		.corrupt     (corrupt),
		.payload_len (payload_len),
		.payload_tag (payload_tag),
		.file_len    (file_len),
		.slot_req    (slot_req),
		.slot_rdata  (slot_rdata),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	srr_slot_ram u_slot_ram (
		.clk   (clk),
		.req   (slot_req),
		.rdata (slot_rdata)
	);

	srr_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.ack_seq      (ack_seq),
		.out_tag      (out_tag),
		.out_len      (out_len),
		.write_offset (write_offset),
		.out_file_len (out_file_len),
		.file_end     (file_end),
		.last         (last)
	);

endmodule
`default_nettype wire

// File: rtl/core/srr_slot_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// srr_slot_ram
// Receive window slot store: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module srr_slot_ram
	import srr_pkg::*;
(
	input  wire logic      clk,
	input  wire slot_req_t req,
	output slot_t          rdata
);

	slot_t mem [MAX_WINDOW];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end

endmodule
`default_nettype wire

// File: rtl/core/srr_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// srr_ctrl
// Packet sequencer: classifies a packet, stores it in the window, drains
// consecutive held slots through the slot RAM and issues the results.
// ---------------------------------------------------------------------------
module srr_ctrl
	import srr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CFG_W-1:0]  cfg_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        func,
	input  wire logic [SEQ_W-1:0]  seq,
	input  wire logic              corrupt,
	input  wire logic [LEN_W-1:0]  payload_len,
	input  wire logic [TAG_W-1:0]  payload_tag,
	input  wire logic [FLEN_W-1:0] file_len,
	output slot_req_t              slot_req,
	input  wire slot_t             slot_rdata,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output res_t                   res
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_EVAL  = 7'b0000010,
		S_START = 7'b0000100,
		S_CLOSE = 7'b0001000,
		S_RD    = 7'b0010000,
		S_DLV   = 7'b0100000,
		S_ACK   = 7'b1000000
	} state_t;

	state_t             state_q;
	logic [CFG_W-1:0]   ws_q;
	logic               receiving_q;
	logic [SEQ_W-1:0]   base_q;
	logic [SEQ_W-1:0]   bytes_q;
	logic               valid_q [MAX_WINDOW];
	// base_q mod (m+1), kept for every window size
	logic [IDX_W-1:0]   resid_q [MAX_WINDOW];
	logic [WIN_W-1:0]   k_q;

	func_t              func_q;
	logic [SEQ_W-1:0]   seq_q;
	logic               corrupt_q;
	logic [LEN_W-1:0]   len_q;
	logic [TAG_W-1:0]   tag_q;
	logic [FLEN_W-1:0]  flen_q;

	logic [WIN_W-1:0]   w;
	logic [IDX_W-1:0]   wsel;
	logic [IDX_W-1:0]   j;
	logic [SEQ_W-1:0]   off;
	logic [SEQ_W-1:0]   back;
	logic [WIN_W:0]     isum;
	logic [IDX_W-1:0]   widx;
	logic               in_win;
	logic               old_pkt;
	logic               hdr_ok;
	logic               in_xfer;

	always_comb begin
		if (ws_q == '0) begin
			w = WIN_W'(1);
		end else if (int'(ws_q) > MAX_WINDOW) begin
			w = WIN_W'(MAX_WINDOW);
		end else begin
			w = WIN_W'(ws_q);
		end
	end

	assign wsel    = IDX_W'(w - WIN_W'(1));
	assign j       = resid_q[wsel];
	assign off     = seq_q - base_q;
	assign back    = base_q - seq_q;
	assign isum    = (WIN_W + 1)'(j) + (WIN_W + 1)'(off[WIN_W-1:0]);
	assign widx    = (isum >= (WIN_W + 1)'(w)) ? IDX_W'(isum - (WIN_W + 1)'(w))
	                                           : IDX_W'(isum);
	assign in_win  = receiving_q && !corrupt_q && (seq_q >= base_q)
	                 && (off < SEQ_W'(w));
	assign old_pkt = receiving_q && !corrupt_q && (seq_q < base_q)
	                 && (back <= SEQ_W'(w));
	assign hdr_ok  = !corrupt_q && (seq_q == '0) && (func_q == FUNC_HEADER);

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;

	// slot written in EVAL is read no earlier than the RD edge after, so the
	// registered read always sees it
	always_comb begin
		slot_req.we            = (state_q == S_EVAL) && in_win;
		slot_req.waddr         = widx;
		slot_req.wdata.tag     = tag_q;
		slot_req.wdata.len     = len_q;
		slot_req.wdata.is_tail = (func_q == FUNC_TAIL);
		slot_req.raddr         = j;
	end

	always_comb begin
		res       = '0;
		res.kind  = KIND_ACK;
		res_valid = 1'b0;
		unique case (state_q)
			S_START: begin
				res_valid    = 1'b1;
				res.kind     = KIND_START;
				res.file_len = flen_q;
			end
			S_CLOSE: begin
				res_valid = 1'b1;
				res.kind  = KIND_CLOSE;
				res.last  = 1'b1;
			end
			S_DLV: begin
				res_valid    = 1'b1;
				res.kind     = KIND_DELIVER;
				res.tag      = slot_rdata.tag;
				res.len      = slot_rdata.len;
				res.offset   = bytes_q;
				res.file_end = slot_rdata.is_tail;
			end
			S_ACK: begin
				res_valid   = 1'b1;
				res.ack_seq = seq_q;
				res.last    = 1'b1;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			func_q    <= func_t'(func);
			seq_q     <= seq;
			corrupt_q <= corrupt;
			len_q     <= payload_len;
			tag_q     <= payload_tag;
			flen_q    <= file_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ws_q        <= WINDOW_RESET;
			receiving_q <= 1'b0;
			base_q      <= '0;
			bytes_q     <= '0;
			k_q         <= '0;
			for (int m = 0; m < MAX_WINDOW; m++) begin
				valid_q[m] <= 1'b0;
				resid_q[m] <= '0;
			end
		end else begin
			if (cfg_we) begin
				ws_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					k_q <= '0;
					if (!receiving_q) begin
						if (func_q == FUNC_FIN) begin
							state_q <= S_CLOSE;
						end else if (hdr_ok) begin
							receiving_q <= 1'b1;
							base_q      <= SEQ_W'(1);
							bytes_q     <= '0;
							for (int m = 0; m < MAX_WINDOW; m++) begin
								resid_q[m] <= (m == 0) ? '0 : IDX_W'(1);
							end
							state_q <= S_START;
						end else begin
							state_q <= S_IDLE;
						end
					end else if (in_win) begin
						valid_q[widx] <= 1'b1;
						state_q       <= S_RD;
					end else if (old_pkt) begin
						state_q <= S_ACK;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_START: begin
					if (res_ready) begin
						state_q <= S_ACK;
					end
				end
				S_CLOSE, S_ACK: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				S_RD: begin
					if (k_q == w || !valid_q[j]) begin
						state_q <= S_ACK;
					end else begin
						state_q <= S_DLV;
					end
				end
				S_DLV: begin
					if (res_ready) begin
						bytes_q <= bytes_q + SEQ_W'(slot_rdata.len);
						if (slot_rdata.is_tail) begin
							receiving_q <= 1'b0;
							base_q      <= '0;
							for (int m = 0; m < MAX_WINDOW; m++) begin
								valid_q[m] <= 1'b0;
								resid_q[m] <= '0;
							end
							state_q <= S_ACK;
						end else begin
							valid_q[j] <= 1'b0;
							base_q     <= base_q + SEQ_W'(1);
							k_q        <= k_q + WIN_W'(1);
							for (int m = 0; m < MAX_WINDOW; m++) begin
								resid_q[m] <= (resid_q[m] == IDX_W'(m)) ? '0
								              : resid_q[m] + IDX_W'(1);
							end
							state_q <= S_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/srr_out_reg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// srr_out_reg
// Result output register; takes a new result in the cycle the old one leaves.
// ---------------------------------------------------------------------------
module srr_out_reg
	import srr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               res_valid,
	output logic                    res_ready,
	input  wire res_t               res,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              kind,
	output logic [SEQ_W-1:0]        ack_seq,
	output logic [TAG_W-1:0]        out_tag,
	output logic [LEN_W-1:0]        out_len,
	output logic [SEQ_W-1:0]        write_offset,
	output logic [FLEN_W-1:0]       out_file_len,
	output logic                    file_end,
	output logic                    last
);

	logic valid_q;
	res_t data_q;

	assign res_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			data_q <= res;
		end
	end

	assign out_valid    = valid_q;
	assign kind         = data_q.kind;
	assign ack_seq      = data_q.ack_seq;
	assign out_tag      = data_q.tag;
	assign out_len      = data_q.len;
	assign write_offset = data_q.offset;
	assign out_file_len = data_q.file_len;
	assign file_end     = data_q.file_end;
	assign last         = data_q.last;

endmodule
`default_nettype wire
